// ===== sv/slrrm_pkg.sv =====
// Shared constants and codes for the stereo linear resampler and ring mixer.
package slrrm_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int SAMPLE_W       = 16;
    localparam int FRAC_W         = 16;
    localparam int PHASE_W        = 20;
    localparam int CFG_IDX_W      = 2;

    localparam logic [PHASE_W-1:0] RATE_STEP_RESET = PHASE_W'(65536);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_MIX   = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_STEP   = 2'd0,
        CFG_MONO_SOURCE = 2'd1,
        CFG_MONO_OUTPUT = 2'd2
    } t_cfg_idx;

endpackage

// ===== sv/stereo_linear_resampler_ring_mixer_top.sv =====
// Top level: request sequencer, resampler phase loop, ring pointers and the mixer output.
// Push: accepted, then per source frame a phase check, plus four steps for each resampled
// frame (phase check, left multiply, right multiply, ring write), all on one shared unit.
// Mix: accepted, then the sum is formed and registered, waiting while an earlier result
// is held. Flush and unused codes finish at acceptance. One request at a time.
// Reset (sync, active low) empties the ring, clears phase and history, sets step 65536.
module stereo_linear_resampler_ring_mixer_top
    import slrrm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PHASE_W-1:0]   i_cfg_data,
    // Request stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // sample_word[31:0], host_left, host_right
    input  logic [1:0]           s_axis_tuser,  // operation
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // mixed_left, mixed_right
    output logic [0:0]           m_axis_tuser   // ring_used
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_L,
        S_MUL_R,
        S_WRITE,
        S_MIX
    } t_state;

    t_state r_state;

    logic [PHASE_W-1:0]        r_rate;
    logic                      r_mono_src;
    logic                      r_mono_out;

    logic [PHASE_W:0]          r_phase;
    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r;
    logic signed [SAMPLE_W-1:0] r_cur_l, r_cur_r;
    logic signed [SAMPLE_W-1:0] r_second;
    logic                      r_has_second;
    logic signed [SAMPLE_W-1:0] r_lv;
    logic signed [SAMPLE_W-1:0] r_host_l, r_host_r;
    logic                      r_used;

    logic [AW-1:0]             r_wr_ptr, r_rd_ptr;
    logic                      r_wr_wrap, r_rd_wrap;

    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;
    logic                      r_out_used;

    logic                      w_accept;
    t_op                       w_op;
    logic signed [SAMPLE_W-1:0] w_lo, w_hi;
    logic                      w_full, w_empty;
    logic [PHASE_W-1:0]        w_step;
    logic signed [SAMPLE_W-1:0] w_ip_prev, w_ip_cur, w_interp;
    logic                      w_wr_en, w_rd_en;
    logic [2*SAMPLE_W-1:0]     w_rd_data;
    logic signed [SAMPLE_W-1:0] w_ring_l, w_ring_r;
    logic signed [SAMPLE_W:0]  w_pair_sum, w_avg17;
    logic signed [SAMPLE_W-1:0] w_avg;
    logic signed [SAMPLE_W-1:0] w_mix_l, w_mix_r;
    logic                      w_out_free;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
        logic signed [SAMPLE_W:0] max_v;
        logic signed [SAMPLE_W:0] min_v;
        max_v = (SAMPLE_W+1)'({1'b0, {(SAMPLE_W-1){1'b1}}});
        min_v = (SAMPLE_W+1)'({2'b11, {(SAMPLE_W-1){1'b0}}});
        if (v > max_v) begin
            return max_v[SAMPLE_W-1:0];
        end else if (v < min_v) begin
            return min_v[SAMPLE_W-1:0];
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_lo          = s_axis_tdata[15:0];
    assign w_hi          = s_axis_tdata[31:16];

    assign w_full  = (r_wr_ptr == r_rd_ptr) && (r_wr_wrap != r_rd_wrap);
    assign w_empty = (r_wr_ptr == r_rd_ptr) && (r_wr_wrap == r_rd_wrap);
    assign w_step  = (r_rate == '0) ? PHASE_W'(1) : r_rate;

    // The shared unit sees the left channel in the left multiply state, the right one after.
    assign w_ip_prev = (r_state == S_MUL_L) ? r_prev_l : r_prev_r;
    assign w_ip_cur  = (r_state == S_MUL_L) ? r_cur_l : r_cur_r;

    slrrm_interp u_interp (
        .i_clk    (i_clk),
        .i_prev   (w_ip_prev),
        .i_cur    (w_ip_cur),
        .i_frac   (r_phase[FRAC_W-1:0]),
        .o_result (w_interp)
    );

    assign w_wr_en = (r_state == S_WRITE) && !w_full;
    assign w_rd_en = w_accept && (w_op == OP_MIX);

    slrrm_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data ({w_interp, r_lv}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_rd_data)
    );

    assign w_ring_l   = w_rd_data[SAMPLE_W-1:0];
    assign w_ring_r   = w_rd_data[2*SAMPLE_W-1:SAMPLE_W];
    assign w_pair_sum = (SAMPLE_W+1)'(w_ring_l) + (SAMPLE_W+1)'(w_ring_r);
    // Halve toward zero: bias a negative sum by one before the arithmetic shift.
    assign w_avg17    = (w_pair_sum + (SAMPLE_W+1)'(w_pair_sum[SAMPLE_W])) >>> 1;
    assign w_avg      = w_avg17[SAMPLE_W-1:0];

    always_comb begin
        w_mix_l = r_host_l;
        w_mix_r = r_mono_out ? '0 : r_host_r;
        if (r_used) begin
            if (r_mono_out) begin
                w_mix_l = sat16((SAMPLE_W+1)'(r_host_l) + (SAMPLE_W+1)'(w_avg));
            end else begin
                w_mix_l = sat16((SAMPLE_W+1)'(r_host_l) + (SAMPLE_W+1)'(w_ring_l));
                w_mix_r = sat16((SAMPLE_W+1)'(r_host_r) + (SAMPLE_W+1)'(w_ring_r));
            end
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rate       <= RATE_STEP_RESET;
            r_mono_src   <= 1'b0;
            r_mono_out   <= 1'b0;
            r_phase      <= '0;
            r_prev_l     <= '0;
            r_prev_r     <= '0;
            r_has_second <= 1'b0;
            r_wr_ptr     <= '0;
            r_wr_wrap    <= 1'b0;
            r_rd_ptr     <= '0;
            r_rd_wrap    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RATE_STEP:   r_rate     <= i_cfg_data;
                    CFG_MONO_SOURCE: r_mono_src <= i_cfg_data[0];
                    CFG_MONO_OUTPUT: r_mono_out <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // In the mix state the output register is refilled below instead.
            if (r_out_valid && m_axis_tready && (r_state != S_MIX)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_op)
                            OP_PUSH: begin
                                r_cur_l      <= w_lo;
                                r_cur_r      <= r_mono_src ? w_lo : w_hi;
                                r_second     <= w_hi;
                                r_has_second <= r_mono_src;
                                r_state      <= S_CHECK;
                            end
                            OP_MIX: begin
                                r_host_l <= s_axis_tdata[47:32];
                                r_host_r <= s_axis_tdata[63:48];
                                r_used   <= !w_empty;
                                r_state  <= S_MIX;
                            end
                            OP_FLUSH: begin
                                r_rd_ptr  <= r_wr_ptr;
                                r_rd_wrap <= r_wr_wrap;
                                r_phase   <= '0;
                                r_prev_l  <= '0;
                                r_prev_r  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK: begin
                    if (r_phase[PHASE_W:FRAC_W] == '0) begin
                        r_state <= S_MUL_L;
                    end else begin
                        // Source frame done: drop one whole unit of phase and shift the history.
                        r_phase  <= {1'b0, PHASE_W'(r_phase - (PHASE_W+1)'(1 << FRAC_W))};
                        r_prev_l <= r_cur_l;
                        r_prev_r <= r_cur_r;
                        if (r_has_second) begin
                            r_cur_l      <= r_second;
                            r_cur_r      <= r_second;
                            r_has_second <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MUL_L: begin
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_lv    <= w_interp;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!w_full) begin
                        if (r_wr_ptr == LAST_ADDR) begin
                            r_wr_ptr  <= '0;
                            r_wr_wrap <= !r_wr_wrap;
                        end else begin
                            r_wr_ptr <= r_wr_ptr + AW'(1);
                        end
                    end
                    r_phase <= r_phase + (PHASE_W+1)'(w_step);
                    r_state <= S_CHECK;
                end
                S_MIX: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_l     <= w_mix_l;
                        r_out_r     <= w_mix_r;
                        r_out_used  <= r_used;
                        if (r_used) begin
                            if (r_rd_ptr == LAST_ADDR) begin
                                r_rd_ptr  <= '0;
                                r_rd_wrap <= !r_rd_wrap;
                            end else begin
                                r_rd_ptr <= r_rd_ptr + AW'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};
    assign m_axis_tuser  = r_out_used;

endmodule

// ===== sv/slrrm_interp.sv =====
// Shared linear interpolation unit: registered multiply, then add and round toward zero.
module slrrm_interp
    import slrrm_pkg::*;
(
    input  logic                       i_clk,
    input  logic signed [SAMPLE_W-1:0] i_prev,
    input  logic signed [SAMPLE_W-1:0] i_cur,
    input  logic        [FRAC_W-1:0]   i_frac,
    output logic signed [SAMPLE_W-1:0] o_result
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int NUM_W  = PROD_W + 1;

    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [FRAC_W:0]     w_frac;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [NUM_W-1:0]    w_num;
    logic signed [NUM_W-1:0]    w_quo;
    logic                       w_round_up;

    assign w_diff = DIFF_W'(i_cur) - DIFF_W'(i_prev);
    assign w_frac = signed'({1'b0, i_frac});

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_diff) * PROD_W'(w_frac);
        r_prev <= i_prev;
    end

    // The quotient by 65536 rounds toward zero, so a negative value with a
    // nonzero fraction moves up by one.
    assign w_num      = (NUM_W'(r_prev) <<< FRAC_W) + NUM_W'(r_prod);
    assign w_quo      = w_num >>> FRAC_W;
    assign w_round_up = w_num[NUM_W-1] && (|w_num[FRAC_W-1:0]);
    assign o_result   = w_quo[SAMPLE_W-1:0] + SAMPLE_W'(w_round_up);

endmodule

// ===== sv/slrrm_ring.sv =====
// Frame ring memory: one write port, one registered read port.
module slrrm_ring
    import slrrm_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [2*SAMPLE_W-1:0]        i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [2*SAMPLE_W-1:0]        o_rd_data
);

    logic [2*SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench: stream requests into the resampler ring mixer and check each mix result.
module tb_top;
    import slrrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int COUNT_SPAN  = 2 * DEPTH;
    localparam int UNITY       = 1 << FRAC_W;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 128;
    localparam int SETTLE_CYC  = 40;

    // Code the block does not decode; it must be dropped without a result.
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        used;
    } mix_out_t;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [1:0]  op;
        logic [31:0] word;
        logic [15:0] hl;
        logic [15:0] hr;
        logic        fixed;
        mix_out_t    want;
    } plan_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PHASE_W-1:0]   i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    stereo_linear_resampler_ring_mixer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow of the block's state and registers.
    logic [31:0]         ring_copy [DEPTH];
    int unsigned         wr_total;
    int unsigned         rd_total;
    logic [PHASE_W-1:0]  phase_acc;
    logic signed [15:0]  hist_l;
    logic signed [15:0]  hist_r;
    logic [PHASE_W-1:0]  rate_reg;
    logic                src_mono;
    logic                out_mono;

    mix_out_t mixed_frames_due [$];
    plan_row_t plan [$];
    int mismatch_count;
    int cycle_count;
    bit calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned frames_held();
        return (wr_total + COUNT_SPAN - rd_total) % COUNT_SPAN;
    endfunction

    function automatic logic [15:0] lerp16(logic signed [15:0] a, logic signed [15:0] b,
                                           int unsigned frac);
        longint acc;
        acc = longint'(a) * UNITY + (longint'(b) - longint'(a)) * longint'(frac);
        return 16'(acc / UNITY);
    endfunction

    function automatic logic [15:0] clip16(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    // Emits every output frame that falls before the next source frame.
    task automatic predict_source_frame(logic signed [15:0] l, logic signed [15:0] r);
        int unsigned rate_inc;
        int unsigned pos;
        rate_inc = (rate_reg != '0) ? int'(rate_reg) : 1;
        pos = phase_acc;
        while (pos < UNITY) begin
            if (frames_held() < DEPTH) begin
                ring_copy[wr_total % DEPTH] = {lerp16(hist_r, r, pos), lerp16(hist_l, l, pos)};
                wr_total = (wr_total + 1) % COUNT_SPAN;
            end
            pos += rate_inc;
        end
        phase_acc = PHASE_W'(pos - UNITY);
        hist_l = l;
        hist_r = r;
    endtask

    task automatic resample_and_mix(input logic [1:0] op, input logic [31:0] word,
                                    input logic [15:0] hl, input logic [15:0] hr,
                                    output bit produced, output mix_out_t res);
        int sl;
        int sr;
        int fl;
        int fr;
        logic [31:0] w;
        produced = 1'b0;
        res = '0;
        case (op)
            OP_PUSH: begin
                if (src_mono) begin
                    predict_source_frame(word[15:0], word[15:0]);
                    predict_source_frame(word[31:16], word[31:16]);
                end else begin
                    predict_source_frame(word[15:0], word[31:16]);
                end
            end
            OP_FLUSH: begin
                rd_total = wr_total;
                phase_acc = '0;
                hist_l = '0;
                hist_r = '0;
            end
            OP_MIX: begin
                sl = $signed(hl);
                sr = out_mono ? 0 : int'($signed(hr));
                if (frames_held() != 0) begin
                    w = ring_copy[rd_total % DEPTH];
                    fl = $signed(w[15:0]);
                    fr = $signed(w[31:16]);
                    if (out_mono) begin
                        sl = sl + (fl + fr) / 2;
                    end else begin
                        sl = sl + fl;
                        sr = sr + fr;
                    end
                    rd_total = (rd_total + 1) % COUNT_SPAN;
                    res.used = 1'b1;
                end
                res.left = clip16(sl);
                res.right = clip16(sr);
                produced = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic flag_error(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endtask

    // Result side: random back-pressure and the comparison against the oldest expectation.
    initial begin
        int hold;
        mix_out_t want;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (mixed_frames_due.size() == 0) begin
                    flag_error($sformatf("unexpected mix result L=%0d R=%0d used=%0b",
                        $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                        m_axis_tuser[0]));
                end else begin
                    want = mixed_frames_due.pop_front();
                    if (m_axis_tdata[15:0] !== want.left || m_axis_tdata[31:16] !== want.right
                            || m_axis_tuser[0] !== want.used)
                        flag_error($sformatf(
                            "mix mismatch: expected L=%0d R=%0d used=%0b, got L=%0d R=%0d used=%0b",
                            $signed(want.left), $signed(want.right), want.used,
                            $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                            m_axis_tuser[0]));
                end
            end
            if (calm) begin
                m_axis_tready <= 1'b1;
            end else if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                hold = idle_span();
            end
        end
    end

    // Sends one request; a fixed expectation, where given, replaces the predicted one.
    task automatic send_request(input logic [1:0] op, input logic [31:0] word,
                                input logic [15:0] hl, input logic [15:0] hr,
                                input logic fixed, input mix_out_t want);
        int gap;
        bit produced;
        mix_out_t res;
        gap = calm ? 0 : idle_span();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {hr, hl, word};
        do @(posedge i_clk); while (!s_axis_tready);
        resample_and_mix(op, word, hl, hr, produced, res);
        if (produced)
            mixed_frames_due.push_back(fixed ? want : res);
    endtask

    // Holds requests off until every expected result is back and the block has gone idle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (mixed_frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [PHASE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RATE_STEP:   rate_reg = data;
            CFG_MONO_SOURCE: src_mono = data[0];
            CFG_MONO_OUTPUT: out_mono = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic plan_row_t req_row(logic [1:0] op, logic [31:0] word,
                                          logic [15:0] hl, logic [15:0] hr);
        plan_row_t row;
        row = '0;
        row.op = op;
        row.word = word;
        row.hl = hl;
        row.hr = hr;
        return row;
    endfunction

    function automatic plan_row_t mix_row(logic [15:0] hl, logic [15:0] hr, logic [15:0] el,
                                          logic [15:0] er, logic eu);
        plan_row_t row;
        row = req_row(OP_MIX, 32'h0, hl, hr);
        row.fixed = 1'b1;
        row.want = '{left: el, right: er, used: eu};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(t_cfg_idx idx, logic [PHASE_W-1:0] data);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.word = 32'(data);
        return row;
    endfunction

    initial begin
        plan_row_t row;
        logic [1:0] op;
        logic [PHASE_W-1:0] rate_pick;
        int push_pct;
        int r;

        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        calm = 1'b0;
        wr_total = 0;
        rd_total = 0;
        phase_acc = '0;
        hist_l = '0;
        hist_r = '0;
        rate_reg = RATE_STEP_RESET;
        src_mono = 1'b0;
        out_mono = 1'b0;

        // At unit rate each push writes the previous source frame, so output lags by one.
        plan.push_back(mix_row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0));
        plan.push_back(req_row(OP_PUSH, 32'h8000_7fff, 16'h0, 16'h0));
        plan.push_back(req_row(OP_PUSH, 32'h7fff_8000, 16'h0, 16'h0));
        plan.push_back(mix_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        plan.push_back(mix_row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1));
        plan.push_back(mix_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        plan.push_back(req_row(OP_SPARE, 32'hdead_beef, 16'h1234, 16'h4321));
        plan.push_back(req_row(OP_PUSH, 32'hffff_ffff, 16'h0, 16'h0));
        plan.push_back(req_row(OP_FLUSH, 32'h0, 16'h0, 16'h0));
        plan.push_back(mix_row(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0));
        plan.push_back(req_row(OP_PUSH, 32'h1234_5678, 16'h0, 16'h0));
        plan.push_back(req_row(OP_PUSH, 32'hedcb_a988, 16'h0, 16'h0));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h8000, 16'h8000));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h7fff, 16'h7fff));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h5555, 16'haaaa));
        // Half rate with a mono mix: the channel average truncates toward zero.
        plan.push_back(cfg_row(CFG_MONO_OUTPUT, 20'd1));
        plan.push_back(cfg_row(CFG_RATE_STEP, 20'd32768));
        plan.push_back(req_row(OP_PUSH, 32'h0000_fffd, 16'h0, 16'h0));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h7fff, 16'h04d2));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h8000, 16'h0000));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h0000, 16'h0000));
        plan.push_back(cfg_row(CFG_MONO_SOURCE, 20'd1));
        plan.push_back(req_row(OP_PUSH, 32'h8000_7fff, 16'h0, 16'h0));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h7fff, 16'h0000));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h8000, 16'h7fff));
        // A zero step counts as the smallest step; one push overfills the ring.
        plan.push_back(cfg_row(CFG_MONO_SOURCE, 20'd0));
        plan.push_back(cfg_row(CFG_RATE_STEP, 20'd0));
        plan.push_back(req_row(OP_PUSH, 32'h7fff_8000, 16'h0, 16'h0));
        plan.push_back(req_row(OP_MIX, 32'h0, 16'h0100, 16'hff00));
        plan.push_back(req_row(OP_FLUSH, 32'h0, 16'h0, 16'h0));
        plan.push_back(cfg_row(CFG_RATE_STEP, RATE_STEP_RESET));
        plan.push_back(cfg_row(CFG_MONO_OUTPUT, 20'd0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            row = plan[k];
            if (row.is_cfg) begin
                quiesce();
                write_register(row.idx, row.word[PHASE_W-1:0]);
            end else begin
                send_request(row.op, row.word, row.hl, row.hr, row.fixed, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph)
                0: rate_pick = 20'd4096;
                1: rate_pick = 20'd524288;
                2: rate_pick = RATE_STEP_RESET;
                default: rate_pick = ($urandom_range(0, 3) == 0)
                    ? PHASE_W'($urandom_range(4096, 524288))
                    : PHASE_W'($urandom_range(4096, 98304));
            endcase
            write_register(CFG_RATE_STEP, rate_pick);
            write_register(CFG_MONO_SOURCE,
                           (ph < 4) ? PHASE_W'(ph & 1) : PHASE_W'($urandom_range(0, 1)));
            write_register(CFG_MONO_OUTPUT,
                           (ph < 4) ? PHASE_W'(ph >> 1) : PHASE_W'($urandom_range(0, 1)));
            calm = (ph == 2);
            push_pct = $urandom_range(25, 75);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 63) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (mixed_frames_due.size() != 0) @(posedge i_clk);
                end
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_FLUSH;
                else if (r < 5)
                    op = OP_SPARE;
                else if (r < 5 + push_pct)
                    op = OP_PUSH;
                else
                    op = OP_MIX;
                send_request(op, {pick_half(), pick_half()}, pick_half(), pick_half(), 1'b0, '0);
            end
            // Closing with a mix means the block is idle once its result is back.
            send_request(OP_MIX, 32'h0, pick_half(), pick_half(), 1'b0, '0);
        end

        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (mixed_frames_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && mixed_frames_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slrrm_pkg.sv
sv/slrrm_interp.sv
sv/slrrm_ring.sv
sv/stereo_linear_resampler_ring_mixer_top.sv
verif/tb_top.sv
